>>> src/crtpp_pkg.sv
// ----------------------------------------------------------------------------
// crtpp_pkg
// Shared types and constants for the CRT pixel post-process pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package crtpp_pkg;

  localparam int COORD_BITS_DEF = 10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [2:0] {
    REG_COLOR_MODE  = 3'd0,
    REG_SCANLINE    = 3'd1,
    REG_NOISE       = 3'd2,
    REG_BRIGHTNESS  = 3'd3,
    REG_HEIGHT      = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CM_COLOR = 2'd0,
    CM_SEPIA = 2'd1,
    CM_MONO  = 2'd2
  } color_mode_t;

  typedef logic [7:0]      chan_t;
  typedef logic [2:0][7:0] rgb_t;

  // reset values
  localparam logic [1:0]  RST_COLOR_MODE = 2'd1;
  localparam logic [6:0]  RST_SCANLINE   = 7'd55;
  localparam logic [6:0]  RST_NOISE      = 7'd35;
  localparam logic [7:0]  RST_BRIGHTNESS = 8'd220;
  localparam logic [10:0] RST_HEIGHT     = 11'd16;

  // hash
  localparam logic [31:0] HASH_KX = 32'd374761393;
  localparam logic [31:0] HASH_KY = 32'd668265263;
  localparam logic [31:0] HASH_KT = 32'd362437;
  localparam logic [31:0] HASH_KM = 32'd1274126177;

  // exact x/1000 for 32-bit x: (x * M) >> 38
  localparam logic [63:0] DIV1000_MUL = 64'd274877907;
  localparam logic [31:0] GRAIN_MOD   = 32'd1000;

  // exact x/100 for x < 43699: (x * 5243) >> 19
  localparam logic [27:0] DIV100_MUL  = 28'd5243;

  localparam logic [15:0] LUMA_R = 16'd77;
  localparam logic [15:0] LUMA_G = 16'd150;
  localparam logic [15:0] LUMA_B = 16'd29;

  localparam logic [14:0] SCAN_K     = 15'd140;
  localparam logic [12:0] NOISE_K    = 13'd40;
  localparam logic [6:0]  GRAIN_BIAS = 7'd2;
  localparam logic [7:0]  GRAIN_MASK = 8'd55;
  localparam logic [7:0]  GRAIN_BASE = 8'd200;
  localparam logic [15:0] VIG_GAIN   = 16'd130;

endpackage

`default_nettype wire

>>> src/crtpp_if.sv
// ----------------------------------------------------------------------------
// crtpp_if
// Valid/ready channels for pixels into and out of the post-process pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

interface crtpp_pix_in_if
  import crtpp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [7:0]            scene_red;
  logic [7:0]            scene_green;
  logic [7:0]            scene_blue;
  logic [COORD_BITS-1:0] column;
  logic [COORD_BITS-1:0] row;
  logic [31:0]           frame_time_ms;
  logic                  snow;

  modport source (
    output valid, scene_red, scene_green, scene_blue, column, row,
           frame_time_ms, snow,
    input  ready
  );

  modport sink (
    input  valid, scene_red, scene_green, scene_blue, column, row,
           frame_time_ms, snow,
    output ready
  );
endinterface

interface crtpp_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (
    output valid, out_red, out_green, out_blue,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue,
    output ready
  );
endinterface

`default_nettype wire

>>> src/crt_pixel_postprocess_core.sv
// ----------------------------------------------------------------------------
// crt_pixel_postprocess_core
// Retro-CRT pixel post-process: snow/grading, scanlines, grain, vignette and
// brightness, as a nine-stage pipeline.
//
// Usage:
//   pix_in  carries one pixel per transaction (scene colour, column, row,
//           frame time, snow flag); pix_out returns one graded pixel for each.
//   cfg_we/cfg_idx/cfg_data write the five control registers; write them
//   only while no pixel is in flight.
//   An accepted pixel passes through stage registers s0 to s8 in order; out
//   valid comes from the valid bit of the last stage.
//   Throughput is one pixel per clock while pix_out.ready stays high; the rate
//   is set by the per-stage valid/ready chain, each stage holding one pixel.
//   When the receiver stalls, the last stage holds its pixel and earlier
//   stages keep filling until each holds one, then pix_in.ready drops.
//   Every stage has its own enable, so a stall loses or repeats nothing.
//   Synchronous reset empties the pipeline and loads the register defaults:
//   sepia, scanlines 55, noise 35, brightness 220, height 16.
// ----------------------------------------------------------------------------
`default_nettype none

module crt_pixel_postprocess_core
  import crtpp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  crtpp_pix_in_if.sink          pix_in,
  crtpp_pix_out_if.source       pix_out
);

  localparam int NS = 9;
  localparam int RW = (COORD_BITS + 5 > 16) ? COORD_BITS + 6 : 17;

  // control registers
  logic [1:0]  color_mode;
  logic [6:0]  scanline_strength;
  logic [6:0]  noise_level;
  logic [7:0]  brightness;
  logic [10:0] screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode        <= RST_COLOR_MODE;
      scanline_strength <= RST_SCANLINE;
      noise_level       <= RST_NOISE;
      brightness        <= RST_BRIGHTNESS;
      screen_height     <= RST_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_COLOR_MODE: color_mode        <= cfg_data[1:0];
        REG_SCANLINE:   scanline_strength <= cfg_data[6:0];
        REG_NOISE:      noise_level       <= cfg_data[6:0];
        REG_BRIGHTNESS: brightness        <= cfg_data[7:0];
        REG_HEIGHT:     screen_height     <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // derived settings, held in registers fed from the control registers
  logic [14:0] scan_prod;
  logic [27:0] scan_rec;
  logic [8:0]  scan_m_next;
  logic [12:0] noise_prod;
  logic [25:0] noise_rec;
  logic [5:0]  grain_p_next;
  logic [10:0] vf_next;
  logic [15:0] vf19_next;
  logic [8:0]  scan_m;
  logic [5:0]  grain_p;
  logic [10:0] vf;
  logic [15:0] vf19;

  always_comb begin
    scan_prod    = 15'(scanline_strength) * SCAN_K;
    scan_rec     = 28'(scan_prod) * DIV100_MUL;
    scan_m_next  = 9'd256 - scan_rec[27:19];
    noise_prod   = 13'(noise_level) * NOISE_K;
    noise_rec    = 26'(noise_prod) * DIV100_MUL[25:0];
    grain_p_next = 6'(GRAIN_BIAS + noise_rec[25:19]);
    vf_next      = (screen_height > 11'd1) ? screen_height - 11'd1 : 11'd1;
    vf19_next    = 16'(vf_next) * 16'd19;
  end

  always_ff @(posedge clk) begin
    scan_m  <= scan_m_next;
    grain_p <= grain_p_next;
    vf      <= vf_next;
    vf19    <= vf19_next;
  end

  // stage handshake
  logic [NS-1:0] v;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v[NS-1] || pix_out.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= pix_in.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign pix_in.ready = en[0];

  // stage 0: hash products, luma sum
  logic [31:0]           s0_hx, s0_hy, s0_ht, s0_gx, s0_gy;
  logic [15:0]           s0_lsum;
  rgb_t                  s0_ch;
  logic [COORD_BITS-1:0] s0_row;
  logic                  s0_snow;
  logic [31:0]           gx_in, gy_in;

  always_comb begin
    gx_in = 32'(pix_in.column) * 32'd7 + 32'd1;
    gy_in = 32'(pix_in.row) * 32'd3 + 32'd2;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_hx   <= 32'(pix_in.column) * HASH_KX;
      s0_hy   <= 32'(pix_in.row) * HASH_KY;
      s0_ht   <= pix_in.frame_time_ms * HASH_KT;
      s0_gx   <= gx_in * HASH_KX;
      s0_gy   <= gy_in * HASH_KY;
      s0_lsum <= 16'(pix_in.scene_red) * LUMA_R + 16'(pix_in.scene_green) * LUMA_G
               + 16'(pix_in.scene_blue) * LUMA_B;
      s0_ch   <= {pix_in.scene_blue, pix_in.scene_green, pix_in.scene_red};
      s0_row  <= pix_in.row;
      s0_snow <= pix_in.snow;
    end
  end

  // stage 1: hash sum and first xorshift, colour grading
  logic [31:0]           hs_sum, hg_sum;
  logic [7:0]            lum;
  logic [8:0]            sep_r;
  logic [15:0]           lg200, lb110, lg245, lb230;
  rgb_t                  graded;
  logic [31:0]           s1_hs, s1_hg;
  rgb_t                  s1_ch;
  logic [COORD_BITS-1:0] s1_row;
  logic                  s1_snow;

  always_comb begin
    hs_sum = s0_hx + s0_hy + s0_ht;
    hg_sum = s0_gx + s0_gy + s0_ht;
    lum    = s0_lsum[15:8];
    sep_r  = {1'b0, lum} + 9'(lum >> 4);
    lg200  = 16'(lum) * 16'd200;
    lb110  = 16'(lum) * 16'd110;
    lg245  = 16'(lum) * 16'd245;
    lb230  = 16'(lum) * 16'd230;
    unique case (color_mode)
      CM_COLOR: graded = s0_ch;
      CM_SEPIA: graded = {lb110[15:8], lg200[15:8], sep_r[8] ? 8'hff : sep_r[7:0]};
      default:  graded = {lb230[15:8], lg245[15:8], lum};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_hs   <= hs_sum ^ (hs_sum >> 13);
      s1_hg   <= hg_sum ^ (hg_sum >> 13);
      s1_ch   <= graded;
      s1_row  <= s0_row;
      s1_snow <= s0_snow;
    end
  end

  // stage 2: hash multiply
  logic [31:0]           s2_hs, s2_hg;
  rgb_t                  s2_ch;
  logic [COORD_BITS-1:0] s2_row;
  logic                  s2_snow;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_hs   <= s1_hs * HASH_KM;
      s2_hg   <= s1_hg * HASH_KM;
      s2_ch   <= s1_ch;
      s2_row  <= s1_row;
      s2_snow <= s1_snow;
    end
  end

  // stage 3: final xorshift, snow select, scanline
  logic [31:0]           hs3, hg3;
  rgb_t                  sel3, scan3;
  logic [16:0]           scan_mul [3];
  logic                  scan_on;
  logic [31:0]           s3_hg;
  rgb_t                  s3_ch;
  logic [COORD_BITS-1:0] s3_row;

  always_comb begin
    hs3     = s2_hs ^ (s2_hs >> 16);
    hg3     = s2_hg ^ (s2_hg >> 16);
    sel3    = s2_snow ? {3{hs3[7:0]}} : s2_ch;
    scan_on = (scanline_strength != 7'd0) && s2_row[0];
    for (int i = 0; i < 3; i++) begin
      scan_mul[i] = 17'(sel3[i]) * 17'(scan_m);
      scan3[i]    = scan_on ? scan_mul[i][15:8] : sel3[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_hg  <= hg3;
      s3_ch  <= scan3;
      s3_row <= s2_row;
    end
  end

  // stage 4: reciprocal multiply for hash / 1000
  logic [63:0]           qprod;
  logic [22:0]           s4_q;
  logic [31:0]           s4_hg;
  rgb_t                  s4_ch;
  logic [COORD_BITS-1:0] s4_row;

  always_comb begin
    qprod = 64'(s3_hg) * DIV1000_MUL;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_q   <= qprod[60:38];
      s4_hg  <= s3_hg;
      s4_ch  <= s3_ch;
      s4_row <= s3_row;
    end
  end

  // stage 5: remainder, grain speck, vignette test
  logic [31:0] rem32;
  logic [9:0]  grain_rem;
  logic        speck;
  logic [7:0]  speck_val;
  logic [RW-1:0] row20;
  logic        vig;
  rgb_t        s5_ch;
  logic        s5_vig;

  always_comb begin
    rem32     = s4_hg - 32'(s4_q) * GRAIN_MOD;
    grain_rem = rem32[9:0];
    speck     = grain_rem < 10'(grain_p);
    speck_val = GRAIN_BASE + (s4_hg[7:0] & GRAIN_MASK);
    row20     = RW'(s4_row) * RW'(20);
    vig       = (row20 < RW'(vf)) || (row20 > RW'(vf19));
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_ch  <= speck ? {3{speck_val}} : s4_ch;
      s5_vig <= vig;
    end
  end

  // stage 6: vignette
  logic [15:0] vig_mul [3];
  rgb_t        vig_ch;
  rgb_t        s6_ch;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vig_mul[i] = 16'(s5_ch[i]) * VIG_GAIN;
      vig_ch[i]  = s5_vig ? vig_mul[i][15:8] : s5_ch[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_ch <= vig_ch;
    end
  end

  // stage 7: brightness product
  logic [15:0] s7_prod [3];

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int i = 0; i < 3; i++) begin
        s7_prod[i] <= 16'(s6_ch[i]) * 16'(brightness);
      end
    end
  end

  // stage 8: divide by 255 and clamp, output register
  logic [16:0] div_sum [3];
  logic [8:0]  div_q   [3];
  rgb_t        out_ch;
  rgb_t        s8_ch;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      div_sum[i] = 17'(s7_prod[i]) + 17'(s7_prod[i][15:8]) + 17'd1;
      div_q[i]   = div_sum[i][16:8];
      out_ch[i]  = div_q[i][8] ? 8'hff : div_q[i][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_ch <= out_ch;
    end
  end

  assign pix_out.valid     = v[8];
  assign pix_out.out_red   = s8_ch[0];
  assign pix_out.out_green = s8_ch[1];
  assign pix_out.out_blue  = s8_ch[2];

  // checks
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    v[4] |-> grain_rem < 10'd1000)
    else $error("grain remainder out of range");

  a_div_range: assert property (@(posedge clk) disable iff (rst)
    v[7] |-> (div_q[0] <= 9'd255) && (div_q[1] <= 9'd255) && (div_q[2] <= 9'd255))
    else $error("brightness quotient above 255");

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    pix_out.ready |-> pix_in.ready)
    else $error("input stalled while output drains");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> v == {NS{1'b1}})
    else $error("input stalled with a free stage");

endmodule

`default_nettype wire
